// ----- sv/wpm_pkg.sv -----
package wpm_pkg;

    // longest pattern that is kept, one cell for each byte
    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    // wildcard bytes in the pattern
    localparam logic [7:0] SYM_STAR = 8'd42;
    localparam logic [7:0] SYM_ANY  = 8'd63;

    // input transaction kinds
    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    // controls broadcast to every cell of the row
    typedef struct packed {
        logic       pat_go;
        logic       text_go;
        logic       clear;
        logic       last;
        logic [7:0] symbol;
    } cell_ctl_t;

endpackage

// ----- sv/wildcard_pattern_match.sv -----
// Wildcard pattern matcher ('?' any one byte, '*' any run of bytes).
// Input channel in_valid/in_stall carries kind, symbol and last. A pattern
// is streamed first (kind 0), its closing byte marked by last; then text
// bytes (kind 1), each string closed by last.
// Output channel out_valid/out_stall carries matched, final_flag, overflow.
// A closing pattern byte gives one result (empty-text match); every text
// byte gives one result telling whether the pattern matches the text so
// far. Other pattern bytes give none.
// The result is registered in the cycle after its transaction is taken, and
// one transaction is taken every cycle unless a held result stalls the input.
// Column update ripples combinationally through 32 cells, setting the clock period.
// Pattern bytes beyond 32 are dropped, overflow is raised and matched reads 0.
// Reset empties the pattern and the output register; the first pattern byte
// after reset or after a closed pattern starts a new pattern.
// When the receiver stalls, the result is held and in_stall rises only while
// a held result is still waiting.
module wildcard_pattern_match (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] symbol,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       final_flag,
    output logic       overflow
);
    import wpm_pkg::*;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_eff;
    logic             pending_reg;
    logic             pending_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             m0_reg;
    logic             m0_next;
    logic             in_take;
    logic             wr_ok;
    logic             out_load;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             matched_reg;
    logic             final_reg;
    logic             overflow_reg;
    logic             sel;
    cell_ctl_t        ctl;

    logic [MAX_PATTERN-1:0] wr_v;
    logic [MAX_PATTERN-1:0] new_v;
    logic [MAX_PATTERN-1:0] old_v;
    logic [MAX_PATTERN-1:0] init_v;
    logic [MAX_PATTERN-1:0] res_v;
    logic [MAX_PATTERN-1:0] tail_v;

    // handshake: take input whenever the output register is free or emptying
    assign in_stall = out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // pattern length bookkeeping
    assign len_eff = pending_reg ? '0 : len_reg;
    assign wr_ok   = (len_eff < LEN_W'(MAX_PATTERN));

    assign ctl.pat_go  = in_take && (kind == KIND_PATTERN);
    assign ctl.text_go = in_take && (kind == KIND_TEXT);
    assign ctl.clear   = pending_reg;
    assign ctl.last    = last;
    assign ctl.symbol  = symbol;

    always_comb
    begin
        priority if (ctl.pat_go && wr_ok)
        begin
            len_next = len_eff + LEN_W'(1);
        end
        else if (ctl.pat_go)
        begin
            len_next = len_eff;
        end
        else
        begin
            len_next = len_reg;
        end
    end

    assign ovf_next     = ctl.pat_go ? ((!pending_reg && ovf_reg) || !wr_ok) : ovf_reg;
    assign pending_next = ctl.pat_go ? last : pending_reg;

    // cell zero of the column: empty pattern against the text so far
    always_comb
    begin
        priority if (ctl.pat_go)
        begin
            m0_next = 1'b1;
        end
        else if (ctl.text_go)
        begin
            m0_next = last;
        end
        else
        begin
            m0_next = m0_reg;
        end
    end

    // row of pattern cells
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        assign wr_v[k]   = wr_ok && (len_eff == LEN_W'(k));
        assign tail_v[k] = (len_next == LEN_W'(k + 1));

        if (k == 0)
        begin : g_first
            wpm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .wr_en     (wr_v[k]),
                .left_new  (1'b0),
                .left_old  (m0_reg),
                .left_init (1'b1),
                .new_bit   (new_v[k]),
                .old_bit   (old_v[k]),
                .init_bit  (init_v[k]),
                .res_bit   (res_v[k])
            );
        end
        else
        begin : g_next
            wpm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .wr_en     (wr_v[k]),
                .left_new  (new_v[k-1]),
                .left_old  (old_v[k-1]),
                .left_init (init_v[k-1]),
                .new_bit   (new_v[k]),
                .old_bit   (old_v[k]),
                .init_bit  (init_v[k]),
                .res_bit   (res_v[k])
            );
        end
    end

    // result is the cell at the end of the pattern; empty pattern never matches text
    assign sel = |(tail_v & res_v);

    assign out_load       = in_take && ((kind == KIND_TEXT) || last);
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            pending_reg   <= 1'b1;
            ovf_reg       <= 1'b0;
            m0_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            pending_reg   <= pending_next;
            ovf_reg       <= ovf_next;
            m0_reg        <= m0_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            matched_reg  <= sel && !ovf_next;
            final_reg    <= last;
            overflow_reg <= ovf_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign matched    = matched_reg;
    assign final_flag = final_reg;
    assign overflow   = overflow_reg;

endmodule

// ----- sv/wpm_cell.sv -----
module wpm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  wpm_pkg::cell_ctl_t ctl,
    input  logic               wr_en,
    input  logic               left_new,
    input  logic               left_old,
    input  logic               left_init,
    output logic               new_bit,
    output logic               old_bit,
    output logic               init_bit,
    output logic               res_bit
);
    import wpm_pkg::*;

    logic [7:0] sym_reg;
    logic       match_reg;
    logic       match_next;
    logic       init_reg;
    logic       init_next;
    logic       is_star;
    logic       hit;

    // pattern byte held by this cell
    always_ff @(posedge clk)
    begin
        if (ctl.pat_go && wr_en)
        begin
            sym_reg <= ctl.symbol;
        end
    end

    // column update: diagonal for literal and '?', ripple from the left for '*'
    assign is_star = (sym_reg == SYM_STAR);
    assign hit     = (sym_reg == ctl.symbol) || (sym_reg == SYM_ANY);

    always_comb
    begin
        if (is_star)
        begin
            new_bit = match_reg | left_new;
        end
        else
        begin
            new_bit = hit & left_old;
        end
    end

    // empty-text column: set while every byte up to here is a star
    always_comb
    begin
        priority if (ctl.pat_go && wr_en)
        begin
            init_next = left_init && (ctl.symbol == SYM_STAR);
        end
        else if (ctl.pat_go && ctl.clear)
        begin
            init_next = 1'b0;
        end
        else
        begin
            init_next = init_reg;
        end
    end

    // pattern bytes and closed texts reload the column from the empty-text column
    always_comb
    begin
        priority if (ctl.pat_go)
        begin
            match_next = init_next;
        end
        else if (ctl.text_go)
        begin
            match_next = ctl.last ? init_reg : new_bit;
        end
        else
        begin
            match_next = match_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            init_reg  <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            init_reg  <= init_next;
        end
    end

    assign old_bit  = match_reg;
    assign init_bit = init_reg;
    assign res_bit  = ctl.pat_go ? init_next : new_bit;

endmodule

// ----- sv/wpm_checker.sv -----
module wpm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       kind,
    input logic       last,
    input logic       out_valid,
    input logic       out_stall,
    input logic       matched,
    input logic       final_flag,
    input logic       overflow
);
    import wpm_pkg::*;

    // a truncated pattern never reports a match
    a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> !matched)
        else $error("match reported on truncated pattern");

    // every text transaction yields a result in the next cycle
    a_text_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (kind == KIND_TEXT)) |=> out_valid)
        else $error("text transaction gave no result");

    // an open pattern byte yields no result
    a_pat_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (kind == KIND_PATTERN) && !last) |=> !out_valid)
        else $error("result appeared for an open pattern byte");

    // input backs up only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(matched) && $stable(final_flag) && $stable(overflow)))
        else $error("stalled result changed");

endmodule

bind wildcard_pattern_match wpm_checker u_wpm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .matched    (matched),
    .final_flag (final_flag),
    .overflow   (overflow)
);

// ----- dv/wildcard_pattern_match_tb.sv -----
module wildcard_pattern_match_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wpm_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 400000;

    // one result of the matcher
    typedef struct packed {
        logic matched;
        logic final_flag;
        logic overflow;
    } match_result_t;

    // predicts the match column and holds the results still owed by the block
    class match_scoreboard;
        logic [7:0]         pattern_bytes [MAX_PATTERN];
        int unsigned        pattern_len;
        bit [MAX_PATTERN:0] live_column;
        bit [MAX_PATTERN:0] start_column;
        bit                 pattern_closed;
        bit                 truncated;
        match_result_t      owed_results [$];
        int                 errors;
        int                 results_checked;
        int                 match_count;
        int                 overflow_count;

        function new();
            pattern_len     = 0;
            start_column    = '0;
            start_column[0] = 1'b1;
            live_column     = start_column;
            pattern_closed  = 1'b1;
            truncated       = 1'b0;
            errors          = 0;
            results_checked = 0;
            match_count     = 0;
            overflow_count  = 0;
        endfunction

        // accepted input transaction: advance the prediction
        function void note_transaction(logic k, logic [7:0] s, logic l);
            match_result_t r;
            bit            diag;
            bit            held;
            if (k == KIND_PATTERN)
            begin
                // first byte after a closed pattern starts a fresh one
                if (pattern_closed)
                begin
                    pattern_len     = 0;
                    truncated       = 1'b0;
                    start_column    = '0;
                    start_column[0] = 1'b1;
                    pattern_closed  = 1'b0;
                end
                if (pattern_len < MAX_PATTERN)
                begin
                    pattern_bytes[pattern_len] = s;
                    pattern_len++;
                    start_column[pattern_len] = start_column[pattern_len - 1] && (s == SYM_STAR);
                end
                else
                begin
                    truncated = 1'b1;
                end
                live_column = start_column;
                if (l)
                begin
                    pattern_closed = 1'b1;
                    r.matched      = start_column[pattern_len] && !truncated;
                    r.final_flag   = 1'b1;
                    r.overflow     = truncated;
                    owed_results.push_back(r);
                end
            end
            else
            begin
                // one column step: diagonal for literals and '?', ripple for '*'
                diag           = live_column[0];
                live_column[0] = 1'b0;
                for (int i = 1; i <= pattern_len; i++)
                begin
                    held = live_column[i];
                    if (pattern_bytes[i - 1] == SYM_STAR)
                        live_column[i] = held | live_column[i - 1];
                    else if (pattern_bytes[i - 1] == s || pattern_bytes[i - 1] == SYM_ANY)
                        live_column[i] = diag;
                    else
                        live_column[i] = 1'b0;
                    diag = held;
                end
                r.matched    = live_column[pattern_len] && !truncated;
                r.final_flag = l;
                r.overflow   = truncated;
                owed_results.push_back(r);
                if (l)
                    live_column = start_column;
            end
        endfunction

        // accepted result: compare with the oldest owed one
        function void check_result(logic m, logic f, logic o);
            match_result_t e;
            if (owed_results.size() == 0)
            begin
                $display("%0t: result with none expected: matched %0b final_flag %0b overflow %0b",
                         $time, m, f, o);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            results_checked++;
            if (m === 1'b1)
                match_count++;
            if (o === 1'b1)
                overflow_count++;
            if (m !== e.matched)
            begin
                $display("%0t: matched expected %0b actual %0b", $time, e.matched, m);
                errors++;
            end
            if (f !== e.final_flag)
            begin
                $display("%0t: final_flag expected %0b actual %0b", $time, e.final_flag, f);
                errors++;
            end
            if (o !== e.overflow)
            begin
                $display("%0t: overflow expected %0b actual %0b", $time, e.overflow, o);
                errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic       kind      = KIND_PATTERN;
    logic [7:0] symbol    = 8'h00;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       matched;
    logic       final_flag;
    logic       overflow;

    match_scoreboard sb;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              sent_count     = 0;
    int              cycle_count    = 0;
    logic [7:0]      stream_bytes [$];

    wildcard_pattern_match u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .symbol     (symbol),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .matched    (matched),
        .final_flag (final_flag),
        .overflow   (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check accepted results, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(matched, final_flag, overflow);
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // present one transaction, hold it until taken
    task automatic send_transaction(input logic k, input logic [7:0] s, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        symbol   <= s;
        last     <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transaction(k, s, l);
        sent_count++;
    endtask

    task automatic send_stream(input logic k, input bit close);
        for (int n = 0; n < stream_bytes.size(); n++)
            send_transaction(k, stream_bytes[n], close && (n == stream_bytes.size() - 1));
    endtask

    // pattern bytes lean on wildcards and a small alphabet
    function automatic logic [7:0] pick_pattern_symbol();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            return SYM_STAR;
        if (r < 45)
            return SYM_ANY;
        if (r < 90)
            return 8'h61 + 8'($urandom_range(2));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_text_symbol();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 85)
            return 8'h61 + 8'($urandom_range(2));
        if (r < 90)
            return SYM_STAR;
        if (r < 93)
            return SYM_ANY;
        return 8'($urandom_range(255));
    endfunction

    // one pattern followed by texts, or a broken sequence now and then
    task automatic random_group();
        logic [7:0]  pat [$];
        int unsigned r;
        int unsigned plen;
        int unsigned shape;
        r = $urandom_range(99);
        if (r < 78)
            plen = $urandom_range(6, 1);
        else if (r < 92)
            plen = $urandom_range(MAX_PATTERN, 7);
        else
            plen = $urandom_range(MAX_PATTERN + 4, MAX_PATTERN + 1);
        for (int n = 0; n < plen; n++)
            pat.push_back(pick_pattern_symbol());
        shape = $urandom_range(99);
        stream_bytes = pat;
        // pattern left open now and then, so the text sees a partial pattern
        send_stream(KIND_PATTERN, shape >= 8);
        repeat ($urandom_range(4, 1))
        begin
            stream_bytes.delete();
            if ($urandom_range(1) == 0)
            begin
                // text shaped after the pattern, sometimes spoilt
                foreach (pat[n])
                begin
                    if (pat[n] == SYM_STAR)
                        repeat ($urandom_range(2)) stream_bytes.push_back(pick_text_symbol());
                    else if (pat[n] == SYM_ANY)
                        stream_bytes.push_back(pick_text_symbol());
                    else
                        stream_bytes.push_back(pat[n]);
                end
                if (stream_bytes.size() == 0)
                    stream_bytes.push_back(pick_text_symbol());
                if ($urandom_range(99) < 30)
                    stream_bytes[$urandom_range(stream_bytes.size() - 1)] = pick_text_symbol();
            end
            else
            begin
                repeat ($urandom_range(8, 1)) stream_bytes.push_back(pick_text_symbol());
            end
            // an unterminated text now and then
            send_stream(KIND_TEXT, !(shape >= 8 && shape < 14 && $urandom_range(1) == 0));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: text with an empty pattern
        send_transaction(KIND_TEXT, "x", 1'b1);
        // lone star, also against a star in the text
        send_transaction(KIND_PATTERN, SYM_STAR, 1'b1);
        send_transaction(KIND_TEXT, SYM_STAR, 1'b1);
        send_transaction(KIND_TEXT, "q", 1'b0);
        send_transaction(KIND_TEXT, 8'hFF, 1'b1);
        // literal, any-byte and trailing star
        send_transaction(KIND_PATTERN, "a", 1'b0);
        send_transaction(KIND_PATTERN, SYM_ANY, 1'b0);
        send_transaction(KIND_PATTERN, SYM_STAR, 1'b1);
        send_transaction(KIND_TEXT, "a", 1'b0);
        send_transaction(KIND_TEXT, "b", 1'b0);
        send_transaction(KIND_TEXT, "c", 1'b1);
        send_transaction(KIND_TEXT, SYM_STAR, 1'b0);
        send_transaction(KIND_TEXT, SYM_STAR, 1'b1);
        // text before the pattern is closed, extreme byte values
        send_transaction(KIND_PATTERN, 8'h00, 1'b0);
        send_transaction(KIND_TEXT, 8'h00, 1'b1);
        send_transaction(KIND_PATTERN, 8'hFF, 1'b1);
        send_transaction(KIND_TEXT, 8'h00, 1'b0);
        send_transaction(KIND_TEXT, 8'hFF, 1'b1);
        // all-star pattern matches the empty text
        send_transaction(KIND_PATTERN, SYM_STAR, 1'b0);
        send_transaction(KIND_PATTERN, SYM_STAR, 1'b1);
        send_transaction(KIND_TEXT, "z", 1'b1);
        send_transaction(KIND_PATTERN, SYM_ANY, 1'b1);
        send_transaction(KIND_TEXT, 8'hAA, 1'b1);

        // random groups over four idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            while (sent_count < (phase + 1) * ITEM_TARGET / 4)
                random_group();
        end
        in_valid <= 1'b0;

        // drain, then let a stray result show itself
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d input transactions over four idling phases, %0d results checked",
                 sent_count, sb.results_checked);
        $display("%0d results matched, %0d reported overflow",
                 sb.match_count, sb.overflow_count);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/wpm_pkg.sv
sv/wpm_cell.sv
sv/wildcard_pattern_match.sv
sv/wpm_checker.sv
dv/wildcard_pattern_match_tb.sv
